FILE: src/sorted_array_priority_queue_top_assert.svh
// Assertion macros for the sorted array priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SAQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/saq_pkg.sv
// Shared types for the sorted array priority queue.
`timescale 1ns / 1ps

package saq_pkg;

    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2
    } t_cmd;

    // Per-cycle control broadcast to every cell.
    typedef struct packed {
        logic ins;  // insert, queue not full
        logic rem;  // remove top, queue not empty
    } t_cell_ctrl;

endpackage

FILE: src/saq_cell.sv
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps

module saq_cell #(
    parameter int PRIO_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  saq_pkg::t_cell_ctrl   i_ctrl,
    input  logic [PRIO_BITS-1:0]  i_new_prio,
    input  logic [DATA_BITS-1:0]  i_new_payload,
    // neighbor toward the top (lower index)
    input  logic                  i_left_s,
    input  logic [PRIO_BITS-1:0]  i_left_prio,
    input  logic [DATA_BITS-1:0]  i_left_payload,
    input  logic                  i_left_valid,
    // neighbor toward the tail (higher index)
    input  logic [PRIO_BITS-1:0]  i_right_prio,
    input  logic [DATA_BITS-1:0]  i_right_payload,
    input  logic                  i_right_valid,
    output logic                  o_s,
    output logic [PRIO_BITS-1:0]  o_prio,
    output logic [DATA_BITS-1:0]  o_payload,
    output logic                  o_valid
);
    import saq_pkg::*;

    logic                 r_valid, n_valid;
    logic [PRIO_BITS-1:0] r_prio,  n_prio;
    logic [DATA_BITS-1:0] r_payload, n_payload;
    logic                 w_s;

    // Cell sits at or below the insert point: empty, or not strictly above new prio.
    assign w_s = !r_valid || (r_prio <= i_new_prio);

    // insert and remove never come together; with neither, the cell holds
    always_comb begin
        n_valid   = r_valid;
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctrl.ins) begin
            if (w_s && i_left_s) begin
                n_valid   = i_left_valid;
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end else if (w_s) begin
                n_valid   = 1'b1;
                n_prio    = i_new_prio;
                n_payload = i_new_payload;
            end
        end else if (i_ctrl.rem) begin
            n_valid   = i_right_valid;
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_s       = w_s;
    assign o_prio    = r_prio;
    assign o_payload = r_payload;
    assign o_valid   = r_valid;

endmodule

FILE: src/sorted_array_priority_queue_top.sv
// Top level of the sorted array priority queue: cell chain, command decode, result register.
// The result of an accepted item appears on the output register in the following cycle.
// One item per cycle while o_stall is low; every cell updates in parallel with its neighbors.
// Reset (synchronous, active low) empties the queue and drops any pending result.
// Cell contents are not cleared; per-cell valid bits mark occupied slots.
`timescale 1ns / 1ps

module sorted_array_priority_queue_top #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [saq_pkg::CMD_W-1:0]    i_cmd,
    input  logic [PRIO_BITS-1:0]         i_entry_prio,
    input  logic [DATA_BITS-1:0]         i_entry_payload,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_ok,
    output logic [PRIO_BITS-1:0]         o_top_prio,
    output logic [DATA_BITS-1:0]         o_top_payload,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic                         o_is_empty,
    output logic                         o_is_full
);
    import saq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Cell 0 holds the top entry; the chain is sorted by descending priority.
    // Insert: cells at or below the insert point shift one step toward the tail,
    // the first of them loads the new item. Remove: every cell takes its tail-side
    // neighbor. Peek reads cell 0 directly.

    logic                 w_s       [DEPTH];
    logic [PRIO_BITS-1:0] w_prio    [DEPTH];
    logic [DATA_BITS-1:0] w_payload [DEPTH];
    logic [DEPTH-1:0]     w_valid;

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 w_acc;
    logic                 w_full, w_empty;
    t_cell_ctrl           w_ctrl;
    logic                 w_ok;
    logic [PRIO_BITS-1:0] w_top_prio;
    logic [DATA_BITS-1:0] w_top_payload;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_ok;
    logic [PRIO_BITS-1:0] r_top_prio;
    logic [DATA_BITS-1:0] r_top_payload;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_empty, r_out_full;

    // Hold the input only while a finished result is still waiting.
    assign o_stall = r_out_valid && i_stall;
    assign w_acc   = i_valid && !o_stall;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // command decode
    always_comb begin
        w_ctrl        = '0;
        w_ok          = 1'b0;
        w_top_prio    = '0;
        w_top_payload = '0;
        n_count       = r_count;
        unique case (t_cmd'(i_cmd))
            CMD_INSERT: begin
                if (!w_full) begin
                    w_ctrl.ins = w_acc;
                    w_ok       = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!w_empty) begin
                    w_ctrl.rem = w_acc;
                    w_ok       = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            CMD_PEEK: begin
                if (!w_empty) begin
                    w_ok          = 1'b1;
                    w_top_prio    = w_prio[0];
                    w_top_payload = w_payload[0];
                end
            end
            default: begin
                // unused code: no operation, reports current status
            end
        endcase
    end

    // cell chain
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic                 w_l_s;
        logic [PRIO_BITS-1:0] w_l_prio;
        logic [DATA_BITS-1:0] w_l_payload;
        logic                 w_l_valid;
        logic [PRIO_BITS-1:0] w_r_prio;
        logic [DATA_BITS-1:0] w_r_payload;
        logic                 w_r_valid;

        if (j == 0) begin : g_head
            assign w_l_s       = 1'b0;
            assign w_l_prio    = '0;
            assign w_l_payload = '0;
            assign w_l_valid   = 1'b0;
        end else begin : g_mid_l
            assign w_l_s       = w_s[j-1];
            assign w_l_prio    = w_prio[j-1];
            assign w_l_payload = w_payload[j-1];
            assign w_l_valid   = w_valid[j-1];
        end

        if (j == DEPTH - 1) begin : g_tail
            assign w_r_prio    = '0;
            assign w_r_payload = '0;
            assign w_r_valid   = 1'b0;
        end else begin : g_mid_r
            assign w_r_prio    = w_prio[j+1];
            assign w_r_payload = w_payload[j+1];
            assign w_r_valid   = w_valid[j+1];
        end

        saq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_ctrl),
            .i_new_prio      (i_entry_prio),
            .i_new_payload   (i_entry_payload),
            .i_left_s        (w_l_s),
            .i_left_prio     (w_l_prio),
            .i_left_payload  (w_l_payload),
            .i_left_valid    (w_l_valid),
            .i_right_prio    (w_r_prio),
            .i_right_payload (w_r_payload),
            .i_right_valid   (w_r_valid),
            .o_s             (w_s[j]),
            .o_prio          (w_prio[j]),
            .o_payload       (w_payload[j]),
            .o_valid         (w_valid[j])
        );
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // result register
    always_comb begin
        if (w_acc) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok          <= w_ok;
            r_top_prio    <= w_top_prio;
            r_top_payload <= w_top_payload;
            r_out_count   <= n_count;
            r_out_empty   <= (n_count == '0);
            r_out_full    <= (n_count == CNT_W'(DEPTH));
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_ok;
    assign o_top_prio    = r_top_prio;
    assign o_top_payload = r_top_payload;
    assign o_count       = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_is_full     = r_out_full;

    // checks
`include "sorted_array_priority_queue_top_assert.svh"

    `SAQ_ASSERT_NOW(a_count_matches_cells, i_clk, i_rst_n, 1'b1, ($countones(w_valid) == int'(r_count)), "cell valid bits disagree with count")

    `SAQ_ASSERT_NEXT(a_remove_decrements, i_clk, i_rst_n, (w_acc && (i_cmd == CMD_REMOVE) && !w_empty), (r_count == $past(r_count) - 1'b1), "remove did not decrement count")

    `SAQ_ASSERT_NOW(a_fail_no_data, i_clk, i_rst_n, (r_out_valid && !r_ok), ((r_top_prio == '0) && (r_top_payload == '0)), "failed result carries entry data")

endmodule

FILE: tb/sv/sorted_array_priority_queue_top_tb.sv
// Self-checking testbench for the sorted array priority queue top level.
`timescale 1ns / 1ps

module sorted_array_priority_queue_top_tb;

    import saq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int DATA_BITS = 16;
    localparam int COUNT_W   = $clog2(DEPTH + 1);

    // The fourth command code is not decoded by the block: no operation.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 4;     // idle cycles after the last owed result, to catch strays

    typedef struct {
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] payload;
    } t_entry;

    typedef struct {
        logic                 ok;
        logic [PRIO_BITS-1:0] top_prio;
        logic [DATA_BITS-1:0] top_payload;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
        logic                 is_full;
    } t_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [CMD_W-1:0]     i_cmd;
    logic [PRIO_BITS-1:0] i_entry_prio;
    logic [DATA_BITS-1:0] i_entry_payload;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_ok;
    logic [PRIO_BITS-1:0] o_top_prio;
    logic [DATA_BITS-1:0] o_top_payload;
    logic [COUNT_W-1:0]   o_count;
    logic                 o_is_empty;
    logic                 o_is_full;

    // Shadow queue, lowest priority first; the top entry is the last one.
    t_entry  shadow_queue[$];
    // Status words still owed by the block, oldest first.
    t_status owed_status[$];

    int mismatches      = 0;
    int results_checked = 0;
    int inserts_taken   = 0;
    int inserts_refused = 0;
    int empty_refusals  = 0;
    int peeks_served    = 0;
    int unused_cmds     = 0;
    int idle_cycles     = 0;

    // Receiver knobs: chance per cycle to start a stall run.
    int stall_pct  = 0;
    int stall_left = 0;

    sorted_array_priority_queue_top #(
        .DEPTH    (DEPTH),
        .PRIO_BITS(PRIO_BITS),
        .DATA_BITS(DATA_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_entry_prio   (i_entry_prio),
        .i_entry_payload(i_entry_payload),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_ok           (o_ok),
        .o_top_prio     (o_top_prio),
        .o_top_payload  (o_top_payload),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the shadow queue and returns the
    // status word the block must report for it.
    // ------------------------------------------------------------------
    function automatic t_status apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [PRIO_BITS-1:0] prio,
                                              input logic [DATA_BITS-1:0] payload);
        t_status st;
        t_entry  fresh;
        int      slot;
        st.ok          = 1'b0;
        st.top_prio    = '0;
        st.top_payload = '0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_queue.size() < DEPTH) begin
                    // Goes just below the first strictly higher priority, so
                    // the newest of equal priorities ends up nearest the top.
                    slot = shadow_queue.size();
                    for (int k = 0; k < shadow_queue.size(); k++) begin
                        if (prio < shadow_queue[k].prio) begin
                            slot = k;
                            break;
                        end
                    end
                    fresh.prio    = prio;
                    fresh.payload = payload;
                    shadow_queue.insert(slot, fresh);
                    st.ok = 1'b1;
                    inserts_taken++;
                end else begin
                    inserts_refused++;
                end
            end
            CMD_REMOVE: begin
                if (shadow_queue.size() > 0) begin
                    void'(shadow_queue.pop_back());
                    st.ok = 1'b1;
                end else begin
                    empty_refusals++;
                end
            end
            CMD_PEEK: begin
                if (shadow_queue.size() > 0) begin
                    st.top_prio    = shadow_queue[shadow_queue.size() - 1].prio;
                    st.top_payload = shadow_queue[shadow_queue.size() - 1].payload;
                    st.ok = 1'b1;
                    peeks_served++;
                end else begin
                    empty_refusals++;
                end
            end
            default: begin
                unused_cmds++;
            end
        endcase
        st.count    = COUNT_W'(shadow_queue.size());
        st.is_empty = (shadow_queue.size() == 0);
        st.is_full  = (shadow_queue.size() == DEPTH);
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Fields are set at a rising edge and held until the
    // block takes them; valid stays up so back-to-back items need no gap.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [PRIO_BITS-1:0] prio,
                             input logic [DATA_BITS-1:0] payload);
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_entry_prio    <= prio;
        i_entry_payload <= payload;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        owed_status.push_back(apply_command(cmd, prio, payload));
    endtask

    // Drops valid for a number of cycles; zero keeps the stream unbroken.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall runs of random length, started at a rate set
    // by the running test.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result taken is compared with the oldest
    // status word owed.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_status.size() == 0) begin
                $display("%0t: unexpected result, ok=%0b count=%0d",
                         $time, o_ok, o_count);
                mismatches++;
            end else begin
                want = owed_status.pop_front();
                check_field("ok",          want.ok,          o_ok);
                check_field("top_prio",    want.top_prio,    o_top_prio);
                check_field("top_payload", want.top_payload, o_top_payload);
                check_field("count",       want.count,       o_count);
                check_field("is_empty",    want.is_empty,    o_is_empty);
                check_field("is_full",     want.is_full,     o_is_full);
                results_checked++;
            end
        end
    end

    // Watchdog: a run with no handshake on either side for too long is hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, owed_status.size());
            $display("FAIL sorted_array_priority_queue_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty queue: remove and peek are refused, the unused code does nothing.
    task automatic test_empty_queue();
        send_item(CMD_REMOVE, 8'hff, 16'hffff);
        send_item(CMD_PEEK,   8'h00, 16'h0000);
        send_item(CMD_UNUSED, 8'h5a, 16'ha5a5);
    endtask

    // Ordering: extremes of priority and payload, ties served newest first.
    task automatic test_ordering();
        stall_pct = 20;
        send_item(CMD_INSERT, 8'h80, 16'h1234);
        send_item(CMD_INSERT, 8'hff, 16'hffff);  // goes straight to the top
        send_item(CMD_INSERT, 8'h00, 16'h0000);  // lands at the bottom
        send_item(CMD_INSERT, 8'h80, 16'haaaa);
        send_item(CMD_INSERT, 8'h80, 16'h5555);  // newest of three equal
        send_item(CMD_REMOVE, 8'h00, 16'h0000);  // drops the 0xff entry
        send_item(CMD_PEEK,   8'h00, 16'h0000);  // must see 0x80 / 0x5555
    endtask

    // Fill to capacity, then a refused insert and the status while full.
    task automatic test_full_queue();
        stall_pct = 0;
        while (shadow_queue.size() < DEPTH)
            send_item(CMD_INSERT, 8'($urandom_range(255)), 16'($urandom));
        send_item(CMD_INSERT, 8'hff, 16'hbeef);
        send_item(CMD_UNUSED, 8'h00, 16'h0000);
        send_item(CMD_PEEK,   8'h00, 16'h0000);
    endtask

    // Random traffic in phases that push the queue toward full, toward empty,
    // hold it mid-way or favour peeks, with varying priority spread and idling.
    task automatic test_random_traffic();
        int sent;
        int phase_left;
        int burst;
        int roll;
        int insert_pct;
        int remove_pct;
        int gap_max;
        int prio_lo;
        int prio_hi;
        logic [CMD_W-1:0]     cmd;
        logic [PRIO_BITS-1:0] prio;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0: begin insert_pct = 75; remove_pct = 12; end  // toward full
                1: begin insert_pct = 15; remove_pct = 70; end  // toward empty
                2: begin insert_pct = 45; remove_pct = 40; end
                default: begin insert_pct = 35; remove_pct = 25; end  // peek heavy
            endcase
            // Narrow windows force many ties; the rest spans the whole range.
            if ($urandom_range(1) == 0) begin
                prio_lo = $urandom_range(252);
                prio_hi = prio_lo + 3;
            end else begin
                prio_lo = 0;
                prio_hi = 255;
            end
            // Some phases run with neither side idling.
            if ($urandom_range(3) == 0) begin
                gap_max   = 0;
                stall_pct = 0;
            end else begin
                gap_max   = $urandom_range(1, 6);
                stall_pct = $urandom_range(5, 60);
            end
            phase_left = $urandom_range(30, 80);
            while (phase_left > 0 && sent < RANDOM_ITEMS) begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && phase_left > 0) begin
                    roll = $urandom_range(99);
                    if (roll < insert_pct)
                        cmd = CMD_INSERT;
                    else if (roll < insert_pct + remove_pct)
                        cmd = CMD_REMOVE;
                    else if (roll < 97)
                        cmd = CMD_PEEK;
                    else
                        cmd = CMD_UNUSED;
                    if ($urandom_range(19) == 0)
                        prio = ($urandom_range(1) == 0) ? 8'h00 : 8'hff;
                    else
                        prio = 8'($urandom_range(prio_hi, prio_lo));
                    send_item(cmd, prio, 16'($urandom));
                    if (cmd != CMD_UNUSED)
                        sent++;
                    burst--;
                    phase_left--;
                end
                pause_sender($urandom_range(gap_max));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_cmd           <= CMD_PEEK;
        i_entry_prio    <= '0;
        i_entry_payload <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_ordering();
        test_full_queue();
        test_random_traffic();

        // Let every owed result come out, then keep clocking to catch strays.
        i_valid   <= 1'b0;
        stall_pct = 0;
        while (owed_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts (%0d refused full), %0d empty refusals, %0d peeks, %0d unused codes",
                 inserts_taken, inserts_refused, empty_refusals, peeks_served, unused_cmds);
        $display("Compared %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS sorted_array_priority_queue_top");
        end else begin
            $display("FAIL sorted_array_priority_queue_top");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/saq_pkg.sv
src/saq_cell.sv
src/sorted_array_priority_queue_top.sv
tb/sv/sorted_array_priority_queue_top_tb.sv
